### hw/rtl/rtt_pkg.sv
// Package: types and constants shared by the range translation table unit
`timescale 1ns / 1ps
package rtt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int TMEM_W        = 16;
    localparam int COUNT_W       = 16;
    localparam int ADDR_W        = 32;
    localparam int WORD_SHIFT    = 3;

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_LOOKUP = 1'b1
    } rtt_op_t;

    typedef struct packed
    {
        rtt_op_t             operation;
        logic [TMEM_W-1:0]   tmem_addr;
        logic [COUNT_W-1:0]  word_count;
        logic [ADDR_W-1:0]   image_addr;
    } rtt_req_t;

    typedef struct packed
    {
        logic                hit;
        logic [ADDR_W-1:0]   mapped_addr;
        logic [COUNT_W-1:0]  remaining;
    } rtt_rsp_t;

    typedef struct packed
    {
        logic [TMEM_W-1:0]   start;
        logic [COUNT_W-1:0]  words;
        logic [ADDR_W-1:0]   source;
    } rtt_entry_t;

    typedef struct packed
    {
        logic                en;
        logic [IDX_W-1:0]    addr;
        rtt_entry_t          data;
    } rtt_wr_t;

endpackage

### hw/rtl/rtt_mem.sv
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module rtt_mem
(
    input  logic                      clk,
    input  rtt_pkg::rtt_wr_t          wr,
    input  logic                      rd_en,
    input  logic [rtt_pkg::IDX_W-1:0] rd_addr,
    output rtt_pkg::rtt_entry_t       rd_data
);

    rtt_pkg::rtt_entry_t mem [rtt_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/rtt_ctrl.sv
// Sequencer: entry walk, record update/append, lookup result register
`timescale 1ns / 1ps
module rtt_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  rtt_pkg::rtt_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output rtt_pkg::rtt_rsp_t         rsp,
    output rtt_pkg::rtt_wr_t          mem_wr,
    output logic                      rd_en,
    output logic [rtt_pkg::IDX_W-1:0] rd_addr,
    input  rtt_pkg::rtt_entry_t       rd_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [rtt_pkg::IDX_W:0]   N_WIDE   = (rtt_pkg::IDX_W + 1)'(rtt_pkg::TABLE_ENTRIES);
    localparam logic [rtt_pkg::CNT_W-1:0] N_CNT    = rtt_pkg::CNT_W'(rtt_pkg::TABLE_ENTRIES);
    localparam logic [rtt_pkg::IDX_W-1:0] LAST_IDX = rtt_pkg::IDX_W'(rtt_pkg::TABLE_ENTRIES - 1);

    state_t                      state_reg, state_next;
    rtt_pkg::rtt_req_t           item_reg, item_next;
    logic [rtt_pkg::CNT_W-1:0]   k_reg, k_next;
    logic                        pend_reg, pend_next;
    logic [rtt_pkg::IDX_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [rtt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [rtt_pkg::IDX_W-1:0]   head_reg, head_next;
    logic                        hit_reg, hit_next;
    rtt_pkg::rtt_entry_t         ent_reg, ent_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    rtt_pkg::rtt_rsp_t           rsp_reg, rsp_next;

    logic [rtt_pkg::CNT_W-1:0]   k_dec;
    logic [rtt_pkg::IDX_W:0]     phys_sum;
    logic [rtt_pkg::IDX_W-1:0]   phys;
    logic [rtt_pkg::TMEM_W:0]    range_end;
    logic                        match_rec;
    logic                        match_lkp;
    logic                        match;
    logic [rtt_pkg::TMEM_W-1:0]  offset;
    rtt_pkg::rtt_entry_t         new_entry;

    always_comb
    begin
        k_dec     = k_reg - 1'b1;
        phys_sum  = {1'b0, head_reg} + {1'b0, k_dec[rtt_pkg::IDX_W-1:0]};
        if (phys_sum >= N_WIDE)
        begin
            phys_sum = phys_sum - N_WIDE;
        end
        phys      = phys_sum[rtt_pkg::IDX_W-1:0];
        range_end = {1'b0, rd_data.start} + {1'b0, rd_data.words};
        match_rec = pend_reg && (rd_data.start == item_reg.tmem_addr);
        match_lkp = pend_reg && ({1'b0, item_reg.tmem_addr} >= {1'b0, rd_data.start})
                    && ({1'b0, item_reg.tmem_addr} < range_end);
        match     = (item_reg.operation == rtt_pkg::OP_LOOKUP) ? match_lkp : match_rec;
        offset    = item_reg.tmem_addr - ent_reg.start;
        new_entry = '{start: item_reg.tmem_addr, words: item_reg.word_count,
                      source: item_reg.image_addr};
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        hit_next       = hit_reg;
        ent_next       = ent_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_wr         = '0;
        rd_en          = 1'b0;
        rd_addr        = phys;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    k_next     = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (match)
                begin
                    if (item_reg.operation == rtt_pkg::OP_RECORD)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = pend_addr_reg;
                        mem_wr.data = new_entry;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        hit_next   = 1'b1;
                        ent_next   = rd_data;
                        state_next = ST_DONE;
                    end
                end
                else if (k_reg != '0)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = phys;
                    k_next         = k_dec;
                end
                else if (item_reg.operation == rtt_pkg::OP_RECORD)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.data = new_entry;
                    if (count_reg < N_CNT)
                    begin
                        mem_wr.addr = count_reg[rtt_pkg::IDX_W-1:0];
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        // drop oldest: overwrite it and advance the head
                        mem_wr.addr = head_reg;
                        head_next   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    if (hit_reg)
                    begin
                        rsp_next.hit         = 1'b1;
                        rsp_next.mapped_addr = ent_reg.source
                                               + (rtt_pkg::ADDR_W'(offset) << rtt_pkg::WORD_SHIFT);
                        rsp_next.remaining   = ent_reg.start + ent_reg.words
                                               - item_reg.tmem_addr;
                    end
                    else
                    begin
                        rsp_next = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_addr_reg <= pend_addr_next;
        hit_reg       <= hit_next;
        ent_reg       <= ent_next;
        rsp_reg       <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/tmem_range_translation_table_unit.sv
// Top level: texture memory range translation table
`timescale 1ns / 1ps
// One word in flight at a time; req_ready is high only while idle.
// Lookup: the walk ends in ST_DONE, which registers the result word; req_ready
// returns with rsp_valid. The walk reads one entry per cycle, newest to oldest.
// Record: req_ready stays low for the walk and the table write; no result word.
// A result held by the receiver stalls the next lookup in its last cycle.
// Reset clears the entry count and ring head; entry memory is not cleared.
module tmem_range_translation_table_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rtt_pkg::rtt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rtt_pkg::rtt_rsp_t rsp
);

    rtt_pkg::rtt_wr_t          mem_wr;
    logic                      rd_en;
    logic [rtt_pkg::IDX_W-1:0] rd_addr;
    rtt_pkg::rtt_entry_t       rd_data;

    rtt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_wr    (mem_wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    rtt_mem u_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
